FILE: rtl/hfp_pkg.sv
// Package for the response frame parser: codes, constants, result word type.
`default_nettype none
package hfp_pkg;

  localparam int unsigned LONG_ADDR_BYTES = 5;
  localparam int unsigned ADDR_CNT_W      = 9;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
  localparam logic [7:0] DELIM_LONG    = 8'h82;
  localparam logic [7:0] DELIM_SHORT   = 8'h02;

  typedef enum logic [3:0] {
    PH_PREAMBLE = 4'd0,
    PH_ADDRESS  = 4'd2,
    PH_COMMAND  = 4'd3,
    PH_COUNT    = 4'd4,
    PH_STATUS   = 4'd5,
    PH_DATA     = 4'd6,
    PH_CHECK    = 4'd7,
    PH_IGNORED  = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    KIND_PREAMBLE = 4'd0,
    KIND_DELIM    = 4'd1,
    KIND_ADDRESS  = 4'd2,
    KIND_COMMAND  = 4'd3,
    KIND_COUNT    = 4'd4,
    KIND_STATUS   = 4'd5,
    KIND_DATA     = 4'd6,
    KIND_CHECK    = 4'd7,
    KIND_IGNORED  = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] position;
    logic [7:0] value;
    logic       long_fmt;
    logic [7:0] pre_total;
    logic       bad_delim;
    logic       frame_end;
    logic       check_ok;
  } res_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hfp_core.sv
// Parser state registers and the per-word field tagging logic.
`default_nettype none
module hfp_core
  import hfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_start,
  output res_t            res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] pre_cnt_r, pre_cnt_nxt;
  logic       long_r, long_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] xor_r, xor_nxt;

  phase_t     ph;
  logic [7:0] pc, pos, x;
  logic [ADDR_CNT_W-1:0] addr_len, pos_p1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IGNORED;
      pre_cnt_r <= '0;
      long_r    <= 1'b0;
      pos_r     <= '0;
      len_r     <= '0;
      xor_r     <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      pre_cnt_r <= pre_cnt_nxt;
      long_r    <= long_nxt;
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      xor_r     <= xor_nxt;
    end
  end

  always_comb begin
    // restart the frame on a start word; format is kept
    ph  = frame_start ? PH_PREAMBLE : phase_r;
    pc  = frame_start ? 8'd0 : pre_cnt_r;
    pos = frame_start ? 8'd0 : pos_r;
    x   = frame_start ? 8'd0 : xor_r;
    addr_len = long_r ? ADDR_CNT_W'(LONG_ADDR_BYTES) : ADDR_CNT_W'(1);
    pos_p1   = {1'b0, pos} + ADDR_CNT_W'(1);

    phase_nxt   = ph;
    pre_cnt_nxt = pc;
    long_nxt    = long_r;
    pos_nxt     = pos;
    len_nxt     = len_r;
    xor_nxt     = x ^ rx_byte;

    res.kind      = KIND_IGNORED;
    res.position  = pos;
    res.value     = rx_byte;
    res.bad_delim = 1'b0;
    res.frame_end = 1'b0;
    res.check_ok  = 1'b0;

    case (ph)
      PH_PREAMBLE: begin
        xor_nxt = x;
        if (rx_byte == PREAMBLE_BYTE) begin
          res.kind     = KIND_PREAMBLE;
          res.position = pc;
          pre_cnt_nxt  = sat_inc(pc);
        end else begin
          res.kind     = KIND_DELIM;
          res.position = 8'd0;
          if (rx_byte == DELIM_LONG) long_nxt = 1'b1;
          else if (rx_byte == DELIM_SHORT) long_nxt = 1'b0;
          else res.bad_delim = 1'b1;
          xor_nxt   = rx_byte;
          pos_nxt   = 8'd0;
          phase_nxt = PH_ADDRESS;
        end
      end
      PH_ADDRESS: begin
        res.kind = KIND_ADDRESS;
        if (pos_p1 >= addr_len) begin
          pos_nxt   = 8'd0;
          phase_nxt = PH_COMMAND;
        end else begin
          pos_nxt = pos_p1[7:0];
        end
      end
      PH_COMMAND: begin
        res.kind  = KIND_COMMAND;
        pos_nxt   = 8'd0;
        phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        res.kind  = KIND_COUNT;
        len_nxt   = rx_byte;
        pos_nxt   = 8'd0;
        phase_nxt = PH_STATUS;
      end
      PH_STATUS: begin
        res.kind = KIND_STATUS;
        if (pos >= 8'd1) begin
          pos_nxt   = 8'd0;
          phase_nxt = (len_r == 8'd0) ? PH_CHECK : PH_DATA;
        end else begin
          pos_nxt = pos_p1[7:0];
        end
      end
      PH_DATA: begin
        res.kind = KIND_DATA;
        if (pos_p1 >= {1'b0, len_r}) begin
          pos_nxt   = 8'd0;
          phase_nxt = PH_CHECK;
        end else begin
          pos_nxt = pos_p1[7:0];
        end
      end
      PH_CHECK: begin
        res.kind      = KIND_CHECK;
        res.frame_end = 1'b1;
        res.check_ok  = (rx_byte == x);
        xor_nxt       = x;
        pos_nxt       = 8'd0;
        phase_nxt     = PH_IGNORED;
      end
      default: begin
        res.kind  = KIND_IGNORED;
        xor_nxt   = x;
        phase_nxt = PH_IGNORED;
        pos_nxt   = sat_inc(pos);
      end
    endcase

    res.long_fmt  = long_nxt;
    res.pre_total = pre_cnt_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/hart_frame_parser.sv
// Top level of the response frame parser: input register, parser core, result register.
// Each word is held in the input register and its result word in the result register.
// Throughput: one word per cycle while the sink does not stall; the parser state advances with each accepted word.
// The input register still accepts while a finished result waits for the sink, but only while it is empty.
// Reset (synchronous, rst_n low) empties both registers, clears counters,
// XOR and format, and puts the parser in the ignored phase.
`default_nettype none
module hart_frame_parser
  import hfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_field_kind,
  output logic [7:0]      out_field_position,
  output logic [7:0]      out_byte_value,
  output logic            out_long_format,
  output logic [7:0]      out_preamble_total,
  output logic            out_bad_delimiter,
  output logic            out_frame_end,
  output logic            out_check_ok
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       out_vld_r;
  res_t       out_r;
  res_t       res;
  logic       advance;

  // advance the input word into the result register when it is free
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (advance) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r  <= in_rx_byte;
      in_start_r <= in_frame_start;
    end
    if (advance) out_r <= res;
  end

  hfp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .rx_byte     (in_byte_r),
    .frame_start (in_start_r),
    .res         (res)
  );

  assign out_valid          = out_vld_r;
  assign out_field_kind     = out_r.kind;
  assign out_field_position = out_r.position;
  assign out_byte_value     = out_r.value;
  assign out_long_format    = out_r.long_fmt;
  assign out_preamble_total = out_r.pre_total;
  assign out_bad_delimiter  = out_r.bad_delim;
  assign out_frame_end      = out_r.frame_end;
  assign out_check_ok       = out_r.check_ok;

`ifndef ASSERT_OFF
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

  a_end_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.frame_end == (out_r.kind == KIND_CHECK)))
    else $error("frame end not aligned with check word");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.check_ok |-> out_r.frame_end)
    else $error("check ok outside frame end");

  a_bad_on_delim: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.bad_delim |-> (out_r.kind == KIND_DELIM))
    else $error("bad delimiter flag on non-delimiter word");

  a_preamble_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.kind == KIND_PREAMBLE) |->
      (out_r.position < out_r.pre_total) ||
      (out_r.position == 8'hFF && out_r.pre_total == 8'hFF))
    else $error("preamble position ahead of preamble total");
`endif

endmodule
`default_nettype wire

FILE: test/hfp_checker.sv
// Checker for the response frame parser: tags each accepted byte and compares result words.
`default_nettype none
module hfp_checker
  import hfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_start,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [3:0] out_field_kind,
  input  wire logic [7:0] out_field_position,
  input  wire logic [7:0] out_byte_value,
  input  wire logic       out_long_format,
  input  wire logic [7:0] out_preamble_total,
  input  wire logic       out_bad_delimiter,
  input  wire logic       out_frame_end,
  input  wire logic       out_check_ok,
  output int              mismatches,
  output int              pending,
  output int              results,
  output int              frames,
  output int              good_checks,
  output int              bad_delims
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state as seen from the byte stream
  phase_t     phase;
  logic [7:0] pre_cnt;
  logic       fmt_long;
  logic [7:0] pos_cnt;
  logic [7:0] data_len;
  logic [7:0] xor_acc;

  res_t pending_tags[$];
  res_t want;
  res_t seen;

  function automatic res_t tag_byte(input logic [7:0] b, input logic start);
    res_t r;
    int   alen;
    alen = fmt_long ? LONG_ADDR_BYTES : 1;
    r = '0;
    r.value = b;
    r.position = pos_cnt;
    if (start) begin
      phase = PH_PREAMBLE;
      pre_cnt = '0;
      pos_cnt = '0;
      xor_acc = '0;
      r.position = '0;
    end
    case (phase)
      PH_PREAMBLE: begin
        if (b == PREAMBLE_BYTE) begin
          r.kind = KIND_PREAMBLE;
          r.position = pre_cnt;
          if (pre_cnt != 8'hFF) pre_cnt = pre_cnt + 8'd1;
        end else begin
          r.kind = KIND_DELIM;
          r.position = '0;
          // unknown delimiter keeps the previous format
          if (b == DELIM_LONG) fmt_long = 1'b1;
          else if (b == DELIM_SHORT) fmt_long = 1'b0;
          else r.bad_delim = 1'b1;
          xor_acc = b;
          pos_cnt = '0;
          phase = PH_ADDRESS;
        end
      end
      PH_ADDRESS: begin
        r.kind = KIND_ADDRESS;
        xor_acc ^= b;
        if (int'(pos_cnt) + 1 >= alen) begin
          pos_cnt = '0;
          phase = PH_COMMAND;
        end else begin
          pos_cnt = pos_cnt + 8'd1;
        end
      end
      PH_COMMAND: begin
        r.kind = KIND_COMMAND;
        xor_acc ^= b;
        pos_cnt = '0;
        phase = PH_COUNT;
      end
      PH_COUNT: begin
        r.kind = KIND_COUNT;
        xor_acc ^= b;
        data_len = b;
        pos_cnt = '0;
        phase = PH_STATUS;
      end
      PH_STATUS: begin
        r.kind = KIND_STATUS;
        xor_acc ^= b;
        if (pos_cnt >= 8'd1) begin
          pos_cnt = '0;
          phase = (data_len == 8'd0) ? PH_CHECK : PH_DATA;
        end else begin
          pos_cnt = pos_cnt + 8'd1;
        end
      end
      PH_DATA: begin
        r.kind = KIND_DATA;
        xor_acc ^= b;
        if (int'(pos_cnt) + 1 >= int'(data_len)) begin
          pos_cnt = '0;
          phase = PH_CHECK;
        end else begin
          pos_cnt = pos_cnt + 8'd1;
        end
      end
      PH_CHECK: begin
        r.kind = KIND_CHECK;
        r.frame_end = 1'b1;
        r.check_ok = (b == xor_acc);
        pos_cnt = '0;
        phase = PH_IGNORED;
      end
      default: begin
        r.kind = KIND_IGNORED;
        phase = PH_IGNORED;
        if (pos_cnt != 8'hFF) pos_cnt = pos_cnt + 8'd1;
      end
    endcase
    r.long_fmt = fmt_long;
    r.pre_total = pre_cnt;
    return r;
  endfunction

  function automatic string show_tag(input res_t r);
    return $sformatf("kind %0d pos %0d byte %h long %b pre %0d bad %b end %b ok %b",
                     r.kind, r.position, r.value, r.long_fmt, r.pre_total,
                     r.bad_delim, r.frame_end, r.check_ok);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PH_IGNORED;
      pre_cnt = '0;
      fmt_long = 1'b0;
      pos_cnt = '0;
      data_len = '0;
      xor_acc = '0;
      pending_tags.delete();
      mismatches = 0;
      pending = 0;
      results = 0;
      frames = 0;
      good_checks = 0;
      bad_delims = 0;
    end else begin
      if (in_valid && !in_stall) begin
        want = tag_byte(in_rx_byte, in_frame_start);
        if (want.frame_end) frames++;
        if (want.check_ok) good_checks++;
        if (want.bad_delim) bad_delims++;
        pending_tags.push_back(want);
      end
      if (out_valid && !out_stall) begin
        results++;
        seen.kind = kind_t'(out_field_kind);
        seen.position = out_field_position;
        seen.value = out_byte_value;
        seen.long_fmt = out_long_format;
        seen.pre_total = out_preamble_total;
        seen.bad_delim = out_bad_delimiter;
        seen.frame_end = out_frame_end;
        seen.check_ok = out_check_ok;
        if (pending_tags.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result word: %s", $realtime, show_tag(seen));
        end else begin
          want = pending_tags.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, results);
              $display("  expected %s", show_tag(want));
              $display("  actual   %s", show_tag(seen));
            end
          end
        end
      end
      pending = pending_tags.size();
    end
  end

endmodule
`default_nettype wire

FILE: test/tb_hart_frame_parser.sv
// Testbench top for the response frame parser: clock, reset, byte stimulus and verdict.
`default_nettype none
module tb_hart_frame_parser;
  import hfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_frame_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_field_kind;
  logic [7:0] out_field_position;
  logic [7:0] out_byte_value;
  logic       out_long_format;
  logic [7:0] out_preamble_total;
  logic       out_bad_delimiter;
  logic       out_frame_end;
  logic       out_check_ok;

  int mismatches, pending, results, frames, good_checks, bad_delims;
  int send_idle = 0;
  int recv_stall = 0;
  int bytes_sent = 0;
  logic cur_long = 1'b0;

  hart_frame_parser i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_rx_byte, .in_frame_start,
    .out_valid, .out_stall, .out_field_kind, .out_field_position, .out_byte_value,
    .out_long_format, .out_preamble_total, .out_bad_delimiter, .out_frame_end,
    .out_check_ok
  );

  hfp_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_rx_byte, .in_frame_start,
    .out_valid, .out_stall, .out_field_kind, .out_field_position, .out_byte_value,
    .out_long_format, .out_preamble_total, .out_bad_delimiter, .out_frame_end,
    .out_check_ok, .mismatches, .pending, .results, .frames, .good_checks, .bad_delims
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic st);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_frame_start <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // stretch 1: long preamble, 2: full data field, 3: long ignored tail
  task automatic send_frame(input int stretch);
    logic [7:0] body[$];
    logic [7:0] d;
    logic [7:0] sum;
    logic       lng;
    logic       first;
    int         npre, alen, nlen, cut, ntail, r, i;
    r = $urandom_range(99);
    if (stretch == 0 && r < 8) begin
      // noise, with the odd stray frame start
      ntail = $urandom_range(1, 6);
      for (i = 0; i < ntail; i++)
        push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      return;
    end
    if (stretch == 1) npre = 258;
    else if ($urandom_range(3) == 0) npre = 0;
    else npre = $urandom_range(1, 5);
    r = $urandom_range(99);
    if (r < 45) d = DELIM_LONG;
    else if (r < 90) d = DELIM_SHORT;
    else begin
      d = 8'($urandom_range(255));
      if (d == PREAMBLE_BYTE || d == DELIM_LONG || d == DELIM_SHORT) d = 8'h00;
    end
    lng = (d == DELIM_LONG) ? 1'b1 : (d == DELIM_SHORT) ? 1'b0 : cur_long;
    alen = lng ? LONG_ADDR_BYTES : 1;
    if (stretch == 2) nlen = 255;
    else if ($urandom_range(29) == 0) nlen = $urandom_range(7, 255);
    else nlen = $urandom_range(0, 6);
    body.push_back(d);
    for (i = 0; i < alen; i++) body.push_back(8'($urandom_range(255)));
    body.push_back(8'($urandom_range(255)));
    body.push_back(8'(nlen));
    for (i = 0; i < 2 + nlen; i++) body.push_back(8'($urandom_range(255)));
    sum = '0;
    foreach (body[k]) sum ^= body[k];
    body.push_back(($urandom_range(99) < 85) ? sum : 8'($urandom_range(255)));
    // cut some frames short so the next start lands mid-frame
    if (stretch == 0 && $urandom_range(99) < 10) cut = $urandom_range(0, body.size() - 1);
    else cut = body.size();
    first = 1'b1;
    for (i = 0; i < npre; i++) begin
      push_byte(PREAMBLE_BYTE, first);
      first = 1'b0;
    end
    for (i = 0; i < cut; i++) begin
      push_byte(body[i], first);
      first = 1'b0;
    end
    if (cut > 0) cur_long = lng;
    if (cut == body.size()) begin
      ntail = (stretch == 3) ? 260 : $urandom_range(0, 2);
      for (i = 0; i < ntail; i++) push_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int ph, stop_at;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bytes before any frame start
    push_byte(8'h00, 1'b0);
    // short frame, zero byte count, good check, then one ignored byte
    push_byte(PREAMBLE_BYTE, 1'b1);
    push_byte(DELIM_SHORT, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h64, 1'b0);
    push_byte(8'h55, 1'b0);
    // long frame restarted mid-address by a bad delimiter, which keeps long format
    push_byte(DELIM_LONG, 1'b1);
    push_byte(8'h11, 1'b0);
    push_byte(8'hC3, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h10, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h96, 1'b0);
    push_byte(8'h00, 1'b0);
    cur_long = 1'b1;
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      stop_at = bytes_sent + 395;
      send_frame((ph < 3) ? ph + 1 : 0);
      while (bytes_sent < stop_at) send_frame(0);
      // hold the sender until every result word is back
      drain();
    end

    send_idle = 0;
    recv_stall = 0;
    repeat (8) @(negedge clk);
    $display("Sent %0d bytes over four flow-control modes; %0d result words checked.",
             bytes_sent, results);
    $display("%0d frames closed (%0d with matching check), %0d bad delimiters, %0d mismatches.",
             frames, good_checks, bad_delims, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/hfp_pkg.sv
rtl/hfp_core.sv
rtl/hart_frame_parser.sv
test/hfp_checker.sv
test/tb_hart_frame_parser.sv
